FILE: rtl/core/probability_vector_normalizer_assert.svh
// Assertion macros used by the normalizer top level.
`ifndef PROBABILITY_VECTOR_NORMALIZER_ASSERT_SVH
`define PROBABILITY_VECTOR_NORMALIZER_ASSERT_SVH

// Checked on every rising clock edge while the block is out of reset.
`define PVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define PVN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/pvn_pkg.sv
// Shared constants, payload types and control structs of the probability vector normalizer.
package pvn_pkg;

  // Fixed lane count of the payload and the default number of lanes built.
  localparam int unsigned LANES        = 8;
  localparam int unsigned MAPS_DEFAULT = 8;

  // Field widths.
  localparam int unsigned PROB_W     = 16;
  localparam int unsigned WEIGHT_W   = 15;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned MAP_CNT_W  = 4;
  localparam int unsigned LANE_IDX_W = 3;

  // Configuration port.
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic {
    REG_MAP_COUNT = 1'b0,
    REG_BG_MODE   = 1'b1
  } reg_sel_e;

  localparam logic [MAP_CNT_W-1:0] MAP_COUNT_RESET = 4'd8;
  localparam logic [NORM_W-1:0]    ONE_Q15         = 16'h8000;

  // One input beat: a voxel with its class weights.
  typedef struct packed {
    logic signed [PROB_W-1:0] prob_0;
    logic signed [PROB_W-1:0] prob_1;
    logic signed [PROB_W-1:0] prob_2;
    logic signed [PROB_W-1:0] prob_3;
    logic signed [PROB_W-1:0] prob_4;
    logic signed [PROB_W-1:0] prob_5;
    logic signed [PROB_W-1:0] prob_6;
    logic signed [PROB_W-1:0] prob_7;
    logic                     last_voxel;
  } in_beat_t;

  // One output beat: normalized weights and flags.
  typedef struct packed {
    logic [NORM_W-1:0] norm_0;
    logic [NORM_W-1:0] norm_1;
    logic [NORM_W-1:0] norm_2;
    logic [NORM_W-1:0] norm_3;
    logic [NORM_W-1:0] norm_4;
    logic [NORM_W-1:0] norm_5;
    logic [NORM_W-1:0] norm_6;
    logic [NORM_W-1:0] norm_7;
    logic              empty_voxel;
    logic              end_of_image;
  } out_beat_t;

  // Side information that travels down the pipeline with each voxel.
  typedef struct packed {
    logic empty;
    logic last;
  } side_t;

  // Settings the merging stage needs for the empty-voxel case.
  typedef struct packed {
    logic [LANE_IDX_W-1:0] last_lane;
    logic                  bg_mode;
  } merge_cfg_t;

endpackage

FILE: rtl/core/pvn_lane_div.sv
// One lane: a pipelined restoring divider computing floor(weight * 32768 / sum).
module pvn_lane_div #(
  parameter int unsigned SUM_W = 18,
  parameter int unsigned STEPS = 16
) (
  input  logic                        clk_i,
  input  logic [STEPS-1:0]            en_i,
  input  logic [pvn_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [STEPS-1:0][SUM_W-1:0] div_i,
  output logic [STEPS-1:0]            quot_o
);

  localparam int unsigned REM_W = SUM_W + 1;

  logic [STEPS-2:0][SUM_W-1:0] rem_q;
  logic [STEPS-1:0][STEPS-1:0] quo_q;
  logic [STEPS-1:0][REM_W-1:0] trial;
  logic [STEPS-1:0][REM_W-1:0] diff;
  logic [STEPS-1:0]            fits;

  // Each stage resolves one quotient bit, most significant first.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    // The first stage sees the weight itself; later ones shift in a zero.
    if (k == 0) begin : g_first
      assign trial[k] = REM_W'(weight_i);
    end else begin : g_next
      assign trial[k] = {rem_q[k-1], 1'b0};
    end

    assign diff[k] = trial[k] - {1'b0, div_i[k]};
    assign fits[k] = (trial[k] >= {1'b0, div_i[k]});

    // The last stage needs only its quotient.
    if (k < STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= fits[k] ? diff[k][SUM_W-1:0] : trial[k][SUM_W-1:0];
        end
      end
    end

    if (k == 0) begin : g_q_first
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          quo_q[k] <= {{(STEPS-1){1'b0}}, fits[k]};
        end
      end
    end else begin : g_q_next
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          quo_q[k] <= {quo_q[k-1][STEPS-2:0], fits[k]};
        end
      end
    end
  end

  assign quot_o = quo_q[STEPS-1];

endmodule

FILE: rtl/core/pvn_merge.sv
// Merging stage: combines lane quotients with the empty-voxel rule into the output register.
module pvn_merge #(
  parameter int unsigned MAPS = pvn_pkg::MAPS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [MAPS-1:0][pvn_pkg::QUOT_W-1:0]    quot_i,
  input  pvn_pkg::side_t                         side_i,
  input  pvn_pkg::merge_cfg_t                    cfg_i,
  output pvn_pkg::out_beat_t                     data_o
);

  localparam int unsigned LANES      = pvn_pkg::LANES;
  localparam int unsigned NORM_W     = pvn_pkg::NORM_W;
  localparam int unsigned LANE_IDX_W = pvn_pkg::LANE_IDX_W;

  logic [NORM_W-1:0]  norm [LANES];
  pvn_pkg::out_beat_t data_d;
  pvn_pkg::out_beat_t data_q;

  // Per lane: quotient, or for an empty voxel the background rule; lanes beyond MAPS stay zero.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < MAPS) begin : g_used
      always_comb begin
        if (!side_i.empty) begin
          norm[i] = quot_i[i];
        end else if (cfg_i.bg_mode && (cfg_i.last_lane == LANE_IDX_W'(i))) begin
          norm[i] = pvn_pkg::ONE_Q15;
        end else begin
          norm[i] = '0;
        end
      end
    end else begin : g_absent
      assign norm[i] = '0;
    end
  end

  // Pack the output beat.
  always_comb begin
    data_d.norm_0       = norm[0];
    data_d.norm_1       = norm[1];
    data_d.norm_2       = norm[2];
    data_d.norm_3       = norm[3];
    data_d.norm_4       = norm[4];
    data_d.norm_5       = norm[5];
    data_d.norm_6       = norm[6];
    data_d.norm_7       = norm[7];
    data_d.empty_voxel  = side_i.empty;
    data_d.end_of_image = side_i.last;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/probability_vector_normalizer.sv
// Top level of the probability vector normalizer: config port, sum stage, lanes and pipeline control.
//
//   Channel   Direction  Handshake              Beat
//   config    in         psel/penable/pready    map_count, background_mode
//   voxel     in         in_valid_i/in_ready_o  pvn_pkg::in_beat_t
//   result    out        out_valid_o/out_ready_i pvn_pkg::out_beat_t
//
// One voxel per cycle is sustained while out_ready_i is not held low. The edge that takes
// a beat loads the clipped weights and their sum; then 16 per-lane divider stages (one
// quotient bit each) and the output register follow. Reset clears all valid flags and
// sets the registers to map_count 8 and background_mode 0. Each stage advances when the
// next one is empty or moving, so bubbles close up and input beats are taken while a
// result waits, until all 18 stages hold a voxel.
`include "probability_vector_normalizer_assert.svh"

module probability_vector_normalizer #(
  parameter int unsigned MAPS = pvn_pkg::MAPS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pvn_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pvn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pvn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pvn_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pvn_pkg::out_beat_t                out_data_o
);

  localparam int unsigned LANES      = pvn_pkg::LANES;
  localparam int unsigned PROB_W     = pvn_pkg::PROB_W;
  localparam int unsigned WEIGHT_W   = pvn_pkg::WEIGHT_W;
  localparam int unsigned MAP_CNT_W  = pvn_pkg::MAP_CNT_W;
  localparam int unsigned LANE_IDX_W = pvn_pkg::LANE_IDX_W;
  localparam int unsigned DATA_W     = pvn_pkg::APB_DATA_W;
  localparam int unsigned STEPS      = pvn_pkg::QUOT_W;
  localparam int unsigned SUM_W      = WEIGHT_W + $clog2(MAPS);
  localparam int unsigned NSUM_W     = pvn_pkg::NORM_W + 3;

  localparam logic [MAP_CNT_W-1:0] MAPS_CNT = MAP_CNT_W'(MAPS);

  // Configuration registers and port.
  logic [MAP_CNT_W-1:0] map_count_q;
  logic                 bg_mode_q;
  logic                 cfg_wr;
  pvn_pkg::reg_sel_e    reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = pvn_pkg::reg_sel_e'(paddr[pvn_pkg::REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_count_q <= pvn_pkg::MAP_COUNT_RESET;
      bg_mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        pvn_pkg::REG_MAP_COUNT: map_count_q <= pwdata[MAP_CNT_W-1:0];
        pvn_pkg::REG_BG_MODE:   bg_mode_q   <= pwdata[0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pvn_pkg::REG_MAP_COUNT: prdata = DATA_W'(map_count_q);
      pvn_pkg::REG_BG_MODE:   prdata = DATA_W'(bg_mode_q);
      default:                prdata = '0;
    endcase
  end

  // Effective lane count: zero counts as one, large values saturate.
  logic [MAP_CNT_W-1:0] used_cnt;
  pvn_pkg::merge_cfg_t  merge_cfg;

  always_comb begin
    used_cnt = map_count_q;
    if (map_count_q == '0) begin
      used_cnt = MAP_CNT_W'(1);
    end else if (map_count_q > MAPS_CNT) begin
      used_cnt = MAPS_CNT;
    end
  end

  assign merge_cfg.last_lane = LANE_IDX_W'(used_cnt - MAP_CNT_W'(1));
  assign merge_cfg.bg_mode   = bg_mode_q;

  // Unpack the input beat into lanes.
  logic [PROB_W-1:0] prob [LANES];

  assign prob[0] = in_data_i.prob_0;
  assign prob[1] = in_data_i.prob_1;
  assign prob[2] = in_data_i.prob_2;
  assign prob[3] = in_data_i.prob_3;
  assign prob[4] = in_data_i.prob_4;
  assign prob[5] = in_data_i.prob_5;
  assign prob[6] = in_data_i.prob_6;
  assign prob[7] = in_data_i.prob_7;

  // Clip negative weights, drop unused lanes and sum the rest.
  logic [WEIGHT_W-1:0] w_in [MAPS];
  logic [SUM_W-1:0]    front_sum;

  always_comb begin
    front_sum = '0;
    for (int i = 0; i < MAPS; i++) begin
      if ((MAP_CNT_W'(i) < used_cnt) && !prob[i][PROB_W-1]) begin
        w_in[i] = prob[i][WEIGHT_W-1:0];
      end else begin
        w_in[i] = '0;
      end
      front_sum = front_sum + SUM_W'(w_in[i]);
    end
  end

  // Pipeline control: stage 0 is the sum stage, 1..STEPS the divider, STEPS+1 the output.
  logic [STEPS:0]   vld_q;
  logic             out_vld_q;
  logic [STEPS+1:0] free;
  logic [STEPS+1:0] ld;

  always_comb begin
    free[STEPS+1] = !out_vld_q || out_ready_i;
    for (int j = STEPS; j >= 0; j--) begin
      free[j] = !vld_q[j] || free[j+1];
    end
    ld[0] = free[0] && in_valid_i;
    for (int j = 1; j <= STEPS + 1; j++) begin
      ld[j] = free[j] && vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (free[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int j = 1; j <= STEPS; j++) begin
        if (free[j]) begin
          vld_q[j] <= vld_q[j-1];
        end
      end
      if (free[STEPS+1]) begin
        out_vld_q <= vld_q[STEPS];
      end
    end
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = out_vld_q;

  // Payload of the sum stage and the shared divisor and side pipelines.
  logic [WEIGHT_W-1:0]         w_q [MAPS];
  logic [STEPS-1:0][SUM_W-1:0] d_q;
  pvn_pkg::side_t              side_q [STEPS+1];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      w_q             <= w_in;
      d_q[0]          <= front_sum;
      side_q[0].empty <= (front_sum == '0);
      side_q[0].last  <= in_data_i.last_voxel;
    end
    for (int k = 1; k < STEPS; k++) begin
      if (ld[k]) begin
        d_q[k] <= d_q[k-1];
      end
    end
    for (int k = 1; k <= STEPS; k++) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Divider lanes, all stepping together.
  logic [MAPS-1:0][STEPS-1:0] quot;

  for (genvar l = 0; l < MAPS; l++) begin : g_lane
    pvn_lane_div #(
      .SUM_W (SUM_W),
      .STEPS (STEPS)
    ) u_lane_div (
      .clk_i    (clk_i),
      .en_i     (ld[STEPS:1]),
      .weight_i (w_q[l]),
      .div_i    (d_q),
      .quot_o   (quot[l])
    );
  end

  // Merging stage with the output register.
  pvn_merge #(
    .MAPS (MAPS)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (ld[STEPS+1]),
    .quot_i (quot),
    .side_i (side_q[STEPS]),
    .cfg_i  (merge_cfg),
    .data_o (out_data_o)
  );

  // Sum of the output lanes, used by the checks below.
  logic [NSUM_W-1:0] norm_sum;

  assign norm_sum = NSUM_W'(out_data_o.norm_0) + NSUM_W'(out_data_o.norm_1)
                  + NSUM_W'(out_data_o.norm_2) + NSUM_W'(out_data_o.norm_3)
                  + NSUM_W'(out_data_o.norm_4) + NSUM_W'(out_data_o.norm_5)
                  + NSUM_W'(out_data_o.norm_6) + NSUM_W'(out_data_o.norm_7);

  // An empty output register never blocks the input.
  `PVN_ASSERT_ALWAYS(a_ready_when_drained, !out_vld_q |-> in_ready_o, "input blocked with output empty")

  // A non-empty voxel's fractions add up to one, short by fewer units than there are lanes.
  `PVN_ASSERT(a_norm_sum_range, out_vld_q && !out_data_o.empty_voxel |-> (norm_sum <= NSUM_W'(pvn_pkg::ONE_Q15)) && (norm_sum + NSUM_W'(LANES) > NSUM_W'(pvn_pkg::ONE_Q15)), "normalized lanes do not sum to one")

  // An empty voxel gives either all zeros or exactly one background lane.
  `PVN_ASSERT(a_empty_shape, out_vld_q && out_data_o.empty_voxel |-> norm_sum == (bg_mode_q ? NSUM_W'(pvn_pkg::ONE_Q15) : NSUM_W'(0)), "empty voxel result malformed")

  // A blocked sum stage keeps its voxel.
  `PVN_ASSERT(a_sum_stage_holds, vld_q[0] && !free[1] |=> vld_q[0] && $stable(d_q[0]), "sum stage lost a stalled voxel")

endmodule
